@@ rtl/core/ppmfd_pkg.sv @@
// Shared constants and types of the PPM frame decoder.
package ppmfd_pkg;

    localparam int CHANNELS = 8;
    localparam int CNT_W    = 4;
    localparam int TIME_W   = 16;
    localparam int THR_W    = 15;
    localparam int US_W     = 11;
    localparam int VALUE_W  = 15;
    localparam int SYNC_W   = 8;
    localparam int INDEX_W  = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [THR_W-1:0] THR_RESET = 15'd6000;
    localparam logic [US_W-1:0]  US_MIN    = 11'd1000;
    localparam logic [US_W-1:0]  US_MAX    = 11'd2000;
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CHANNELS);
    localparam logic signed [VALUE_W-1:0] US_CENTRE = 15'sd1500;

    // Register word index on the configuration port.
    localparam logic REG_SYNC_GAP = 1'b0;

    // Result item; the first member listed lies in the highest bits.
    typedef struct packed {
        logic [SYNC_W-1:0]         sync_count;
        logic                      frame_sync;
        logic signed [VALUE_W-1:0] channel_value;
        logic [INDEX_W-1:0]        channel_index;
        logic                      value_valid;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/core/ppmfd_cfg.sv @@
// Configuration register file with its APB-style access port.
module ppmfd_cfg
    import ppmfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [THR_W-1:0]  sync_gap_ticks
);

    logic [THR_W-1:0] thr_reg;
    logic             wr_en;

    assign pready = 1'b1;
    // Only the word index is decoded; byte offsets within a word are ignored.
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_SYNC_GAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (wr_en)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SYNC_GAP)
        begin
            prdata = {{(DATA_W-THR_W){1'b0}}, thr_reg};
        end
    end

    assign sync_gap_ticks = thr_reg;

endmodule

@@ rtl/core/ppmfd_decode.sv @@
// Frame state and per-edge decode of gap, sync and channel value.
module ppmfd_decode
    import ppmfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [TIME_W-1:0] capture_time,
    input  logic [THR_W-1:0]  sync_gap_ticks,
    output result_t           result
);

    logic [TIME_W-1:0] prev_reg,     prev_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic              await_reg,    await_next;
    logic [SYNC_W-1:0] total_reg,    total_next;

    logic [TIME_W-1:0]         gap;
    logic                      is_sync;
    logic [US_W-1:0]           us;
    logic signed [VALUE_W-1:0] dev;
    logic signed [VALUE_W-1:0] scaled;

    assign gap     = capture_time - prev_reg;
    // The gap is read as signed, so a negative gap is never a sync gap.
    assign is_sync = $signed(gap) > $signed({1'b0, sync_gap_ticks});

    // A negative gap clamps to the low end; otherwise halve and clamp.
    always_comb
    begin
        priority if (gap[TIME_W-1])
            us = US_MIN;
        else if (gap[TIME_W-1:1] > {4'b0, US_MAX})
            us = US_MAX;
        else if (gap[TIME_W-1:1] < {4'b0, US_MIN})
            us = US_MIN;
        else
            us = gap[US_W:1];
    end

    assign dev    = $signed({4'b0, us}) - US_CENTRE;
    assign scaled = (dev <<< 4) + (dev <<< 2);

    always_comb
    begin
        prev_next  = capture_time;
        count_next = count_reg;
        await_next = await_reg;
        total_next = total_reg;
        result     = '0;
        if (count_reg < CNT_FULL)
        begin
            if (is_sync)
            begin
                count_next        = '0;
                await_next        = 1'b0;
                total_next        = total_reg + 1'b1;
                result.frame_sync = 1'b1;
            end
            else if (!await_reg)
            begin
                result.value_valid   = 1'b1;
                result.channel_index = count_reg[INDEX_W-1:0];
                result.channel_value = scaled;
                count_next           = count_reg + 1'b1;
            end
        end
        else
        begin
            // Frame full: this edge only rearms the channel count.
            count_next = '0;
            await_next = 1'b0;
        end
        result.sync_count = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
            await_reg <= 1'b1;
            total_reg <= '0;
        end
        else if (step)
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            await_reg <= await_next;
            total_reg <= total_next;
        end
    end

endmodule

@@ rtl/core/ppm_frame_decoder_top.sv @@
// PPM frame decoder: top level with input and result registers.
//
// Input stream (s_axis_*): one item per falling edge of the PPM signal,
// carrying the 16-bit capture timestamp in half-microsecond ticks.
// Output stream (m_axis_*): exactly one result item per input item, with
// the channel value, its index, the sync flag and the running sync count.
// The APB port holds sync_gap_ticks at byte address 0; write it while idle.
// An item is accepted into the input register and moves on into the result
// register once that is free, and m_axis_tvalid rises as it enters the
// result register. Both stages advance together and one item is taken in
// every cycle while the output is drained.
// The decode state updates as an item moves into the result register; the
// gap, compare and scale path is combinational between the two registers.
// Reset clears the timestamp, channel count and sync count, arms the
// sync search and restores the threshold to 6000 ticks.
// When the receiver holds m_axis_tready low the result register keeps its
// item, one further item may wait in the input register, and then
// s_axis_tready falls until the output is taken.
module ppm_frame_decoder_top
    import ppmfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TIME_W-1:0]      s_axis_tdata,   // [15:0] capture_time
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] value_valid, [3:1] channel_index, [18:4] channel_value,
    // [19] frame_sync, [27:20] sync_count, [31:28] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic              in_valid_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg;
    result_t           out_result_reg;

    logic              out_free;
    logic              advance;
    logic [THR_W-1:0]  sync_gap_ticks;
    result_t           result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    ppmfd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sync_gap_ticks (sync_gap_ticks)
    );

    ppmfd_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .capture_time   (in_time_reg),
        .sync_gap_ticks (sync_gap_ticks),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_time_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_result_reg};

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for the PPM frame decoder: a directed table, then random frames.
module tb;
    import ppmfd_pkg::*;

    localparam int REG_SPARE = 1;
    localparam logic [ADDR_W-1:0] SYNC_GAP_ADDR = ADDR_W'(int'(REG_SYNC_GAP) * 4);
    localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(REG_SPARE * 4);
    localparam int GAP_MAX     = 32767;
    localparam int DIR_ROWS    = 24;
    localparam int NUM_PHASES  = 5;
    localparam int PHASE_ITEMS = 205;
    localparam int IDLE_LIMIT  = 2000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 15'sd10000;
    localparam logic signed [VALUE_W-1:0] V_MIN = -15'sd10000;

    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              known;
        result_t           want;
    } edge_row_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TIME_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [ADDR_W-1:0]      paddr         = '0;
    logic [DATA_W-1:0]      pwdata        = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // Decoder state as the bench expects it to be.
    logic [TIME_W-1:0] last_stamp = '0;
    logic [CNT_W-1:0]  chan_count = '0;
    logic              hunting    = 1'b1;
    logic [SYNC_W-1:0] syncs_seen = '0;
    logic [THR_W-1:0]  gap_limit  = THR_RESET;

    result_t  pending_results [$];
    int       fails      = 0;
    int       burst_left = 0;
    bit       tx_bursty  = 1'b1;
    rx_mode_e rx_mode    = RX_RANDOM;
    int       rx_phase   = 0;
    int       stall_left = 0;
    int       idle_count = 0;
    int       frame_pos  = 0;
    int       frame_len  = 0;

    // Expected results are typed in where they follow at once from the gap.
    edge_row_t dir_table [DIR_ROWS] = '{
        '{16'd100,   1'b1, '{8'd0, 1'b0, 15'sd0, 3'd0, 1'b0}},
        '{16'd6100,  1'b1, '{8'd0, 1'b0, 15'sd0, 3'd0, 1'b0}},
        '{16'd12101, 1'b1, '{8'd1, 1'b1, 15'sd0, 3'd0, 1'b0}},
        '{16'd15101, 1'b1, '{8'd1, 1'b0, 15'sd0, 3'd0, 1'b1}},
        '{16'd19101, 1'b1, '{8'd1, 1'b0, V_MAX,  3'd1, 1'b1}},
        '{16'd23103, 1'b1, '{8'd1, 1'b0, V_MAX,  3'd2, 1'b1}},
        '{16'd25103, 1'b1, '{8'd1, 1'b0, V_MIN,  3'd3, 1'b1}},
        '{16'd27102, 1'b1, '{8'd1, 1'b0, V_MIN,  3'd4, 1'b1}},
        '{16'd30103, 1'b1, '{8'd1, 1'b0, 15'sd0, 3'd5, 1'b1}},
        '{16'd30000, 1'b1, '{8'd1, 1'b0, V_MIN,  3'd6, 1'b1}},
        '{16'd62768, 1'b1, '{8'd1, 1'b0, V_MIN,  3'd7, 1'b1}},
        '{16'd7232,  1'b1, '{8'd1, 1'b0, 15'sd0, 3'd0, 1'b0}},
        '{16'd39999, 1'b1, '{8'd2, 1'b1, 15'sd0, 3'd0, 1'b0}},
        '{16'd65535, 1'b1, '{8'd3, 1'b1, 15'sd0, 3'd0, 1'b0}},
        '{16'd2999,  1'b1, '{8'd3, 1'b0, 15'sd0, 3'd0, 1'b1}},
        '{16'd6299,  1'b0, '0},
        '{16'd6299,  1'b1, '{8'd3, 1'b0, V_MIN,  3'd2, 1'b1}},
        '{16'd0,     1'b1, '{8'd3, 1'b0, V_MIN,  3'd3, 1'b1}},
        '{16'd3377,  1'b0, '0},
        '{16'd6901,  1'b0, '0},
        '{16'd9901,  1'b0, '0},
        '{16'd13800, 1'b0, '0},
        '{16'd20000, 1'b1, '{8'd3, 1'b0, 15'sd0, 3'd0, 1'b0}},
        '{16'd26001, 1'b1, '{8'd4, 1'b1, 15'sd0, 3'd0, 1'b0}}
    };

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ppm_frame_decoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] capture_time
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] value_valid, [3:1] channel_index, [18:4] channel_value,
        // [19] frame_sync, [27:20] sync_count, [31:28] zero
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Works out the result of one edge and advances the expected state.
    function automatic result_t decode_edge(input logic [TIME_W-1:0] stamp);
        result_t                  r;
        logic signed [TIME_W-1:0] gap;
        int                       us;
        r = '0;
        gap = stamp - last_stamp;
        last_stamp = stamp;
        if (chan_count < CNT_FULL)
        begin
            if (int'(gap) > int'(gap_limit))
            begin
                chan_count = '0;
                hunting = 1'b0;
                syncs_seen++;
                r.frame_sync = 1'b1;
            end
            else if (!hunting)
            begin
                // A negative gap always ends up at the bottom of the range.
                us = (gap < 0) ? int'(US_MIN) : int'(gap) / 2;
                if (us > int'(US_MAX))
                    us = int'(US_MAX);
                if (us < int'(US_MIN))
                    us = int'(US_MIN);
                r.value_valid   = 1'b1;
                r.channel_index = chan_count[INDEX_W-1:0];
                r.channel_value = VALUE_W'((us - int'(US_CENTRE)) * 20);
                chan_count++;
            end
        end
        else
        begin
            chan_count = '0;
            hunting = 1'b0;
        end
        r.sync_count = syncs_seen;
        return r;
    endfunction

    // Mostly well-formed frames (sync gap, then channel gaps), with some noise.
    function automatic logic [TIME_W-1:0] next_stamp();
        int pick;
        int gap;
        int top;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            frame_pos = 0;
            return TIME_W'($urandom);
        end
        if (frame_pos == 0)
        begin
            frame_len = $urandom_range(1, CHANNELS + 2);
            top = int'(gap_limit) + 6000;
            if (top > GAP_MAX)
                top = GAP_MAX;
            if (int'(gap_limit) >= GAP_MAX)
                gap = GAP_MAX;
            else
                gap = $urandom_range(int'(gap_limit) + 1, top);
        end
        else if (pick < 80)
            gap = $urandom_range(1900, 4100);
        else if (pick < 90)
            gap = $urandom_range(0, 2100);
        else
            gap = $urandom_range(3900, 65535);
        frame_pos = (frame_pos >= frame_len) ? 0 : frame_pos + 1;
        return last_stamp + TIME_W'(gap);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic send_item(input logic [TIME_W-1:0] stamp, input logic known,
                             input result_t want);
        result_t predicted;
        if (tx_bursty && burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do @(posedge clk); while (!s_axis_tready);
        predicted = decode_edge(stamp);
        pending_results.push_back(known ? want : predicted);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Every item yields a result, so an empty queue means the block is idle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == SYNC_GAP_ADDR)
            gap_limit = data[THR_W-1:0];
        @(posedge clk);
    endtask

    task automatic check_gap_readback();
        logic [DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SYNC_GAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        data = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("sync_gap_ticks readback", int'(gap_limit), int'(data));
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[RESULT_W-1:0]);
            check_field("pad bits", 0, int'(m_axis_tdata[OUT_TDATA_W-1:RESULT_W]));
            if (pending_results.size() == 0)
            begin
                $display("%0t result with nothing expected: expected none, actual %h",
                         $time, m_axis_tdata);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("value_valid", int'(want.value_valid), int'(got.value_valid));
                check_field("channel_index", int'(want.channel_index),
                            int'(got.channel_index));
                check_field("channel_value", int'(want.channel_value),
                            int'(got.channel_value));
                check_field("frame_sync", int'(want.frame_sync), int'(got.frame_sync));
                check_field("sync_count", int'(want.sync_count), int'(got.sync_count));
            end
        end
        case (rx_mode)
            RX_STEADY:
                m_axis_tready <= 1'b1;
            RX_RANDOM:
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC:
            begin
                m_axis_tready <= (rx_phase % 7) < 4;
                rx_phase++;
            end
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left = $urandom_range(4, 20);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        endcase
    end

    // Longest quiet spell in a correct run is a sender gap, a long stall or a
    // register access, all far below the limit.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [THR_W-1:0]  setting;
        logic [DATA_W-1:0] wdata;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_gap_readback();
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_table[i].stamp, dir_table[i].known, dir_table[i].want);
        quiesce();
        // A write to an unused register index must leave the threshold alone.
        write_reg(SPARE_ADDR, $urandom);
        check_gap_readback();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiesce();
            case (p)
                0: setting = THR_RESET;
                1: setting = '0;
                2: setting = '1;
                3: setting = THR_W'($urandom_range(2500, 9000));
                default: setting = THR_W'($urandom_range(1, GAP_MAX - 1));
            endcase
            wdata = $urandom;
            wdata[THR_W-1:0] = setting;
            write_reg(SYNC_GAP_ADDR, wdata);
            check_gap_readback();
            tx_bursty = (p != 2);
            rx_mode = rx_mode_e'(p % 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(next_stamp(), 1'b0, '0);
        end
        quiesce();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
